// File: rtl/tlt_pkg.sv
// Package for the task latency tracker: field widths, operation and error codes, the slot
// structure shared by the cell, head and top, and the scan accumulator of head and top.
// No dependencies.
package tlt_pkg;

  localparam int ID_W                  = 32;
  localparam int TIME_W                = 48;
  localparam int MODE_W                = 2;
  localparam int ERR_W                 = 2;
  localparam int DEFAULT_RUNNING_SLOTS = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_BEGIN = 2'd0,
    MODE_END   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNKNOWN_ID = 2'd1,
    ERR_TABLE_FULL = 2'd2
  } err_t;

  // One running-task slot.
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
  } slot_t;

  // What the scan has gathered so far in the current transaction.
  typedef struct packed {
    logic              hit;        // begin: id stored; end: id matched
    logic              run_found;  // query: a running task qualified
    logic [TIME_W-1:0] dur;        // end: elapsed time; query: running maximum
    logic [ID_W-1:0]   id;         // query: id of the running maximum
  } acc_t;

endpackage

// File: rtl/tlt_in_if.sv
// Input channel of the task latency tracker: valid/ready handshake and request payload.
// Depends on tlt_pkg for field widths.
interface tlt_in_if;
  logic                        valid;
  logic                        ready;
  logic [tlt_pkg::MODE_W-1:0]  mode;
  logic [tlt_pkg::ID_W-1:0]    task_id;
  logic [tlt_pkg::TIME_W-1:0]  now;

  modport source (output valid, mode, task_id, now, input ready);
  modport sink   (input valid, mode, task_id, now, output ready);
endinterface

// File: rtl/tlt_out_if.sv
// Result channel of the task latency tracker: valid/ready handshake and result payload.
// Depends on tlt_pkg for field widths.
interface tlt_out_if;
  logic                        valid;
  logic                        ready;
  logic [tlt_pkg::ID_W-1:0]    result_id;
  logic                        found;
  logic                        is_running;
  logic [tlt_pkg::TIME_W-1:0]  duration;
  logic [tlt_pkg::ERR_W-1:0]   error;

  modport source (output valid, result_id, found, is_running, duration, error,
                  input ready);
  modport sink   (input valid, result_id, found, is_running, duration, error,
                  output ready);
endinterface

// File: rtl/task_latency_tracker.sv
// Task latency tracker top level: a ring of RUNNING_SLOTS slot cells rotated past one
// head unit, plus the completed-task record and the output register.
// Each transaction is accepted in IDLE, scans one full ring turn in SCAN (clear skips the
// scan) and ends in FINISH, where its result enters the output register; a new transaction
// is taken only back in IDLE, and a stalled result register holds FINISH until it frees.
// Reset (synchronous, active low) empties all slots, the record and the id counter at once.
// Depends on tlt_pkg, tlt_in_if, tlt_out_if, tlt_cell and tlt_head.
module task_latency_tracker #(
  parameter int RUNNING_SLOTS = tlt_pkg::DEFAULT_RUNNING_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  tlt_in_if.sink           in_ch,
  tlt_out_if.source        out_ch
);

  localparam int CNT_W = (RUNNING_SLOTS > 1) ? $clog2(RUNNING_SLOTS) : 1;

  // IDLE waits for a transaction. SCAN rotates the ring one slot per cycle for
  // one full turn, so every slot passes the head exactly once and the ring
  // ends where it started. FINISH forms the result and commits the record and
  // id counter in the cycle the result enters the output register.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                      state_r;
  logic [CNT_W-1:0]            cnt_r;
  tlt_pkg::mode_t              mode_r;
  logic [tlt_pkg::ID_W-1:0]    key_r;
  logic [tlt_pkg::TIME_W-1:0]  now_r;
  tlt_pkg::acc_t               acc_r;

  logic [tlt_pkg::ID_W-1:0]    next_id_r;
  logic                        best_valid_r;
  logic [tlt_pkg::TIME_W-1:0]  best_dur_r;
  logic [tlt_pkg::ID_W-1:0]    best_id_r;

  logic                        out_valid_r;
  logic [tlt_pkg::ID_W-1:0]    out_rid_r;
  logic                        out_found_r;
  logic                        out_run_r;
  logic [tlt_pkg::TIME_W-1:0]  out_dur_r;
  tlt_pkg::err_t               out_err_r;

  // The ring. Each cell takes its upper neighbor's slot on a rotation; the top
  // cell takes the head slot as modified by the head unit.
  tlt_pkg::slot_t ring_q [RUNNING_SLOTS];
  tlt_pkg::slot_t ring_d [RUNNING_SLOTS];
  tlt_pkg::slot_t head_nxt;
  tlt_pkg::acc_t  acc_nxt;
  logic           shift_en;

  assign shift_en = (state_r == ST_SCAN);

  for (genvar i = 0; i < RUNNING_SLOTS; i++) begin : g_ring
    if (i == RUNNING_SLOTS - 1) begin : g_tail
      assign ring_d[i] = head_nxt;
    end else begin : g_link
      assign ring_d[i] = ring_q[i+1];
    end

    tlt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .slot_in  (ring_d[i]),
      .slot_q   (ring_q[i])
    );
  end

  tlt_head u_head (
    .mode     (mode_r),
    .key      (key_r),
    .now      (now_r),
    .head     (ring_q[0]),
    .acc      (acc_r),
    .head_nxt (head_nxt),
    .acc_nxt  (acc_nxt)
  );

  // The output register takes a new result when it is empty or its current
  // result is being taken in this cycle.
  logic out_free;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);

  // Result and record update, evaluated in FINISH.
  logic [tlt_pkg::ID_W-1:0]    res_rid;
  logic                        res_found;
  logic                        res_run;
  logic [tlt_pkg::TIME_W-1:0]  res_dur;
  tlt_pkg::err_t               res_err;
  logic                        best_upd;

  always_comb begin
    res_rid   = '0;
    res_found = 1'b0;
    res_run   = 1'b0;
    res_dur   = '0;
    res_err   = tlt_pkg::ERR_NONE;
    best_upd  = 1'b0;
    case (mode_r)
      tlt_pkg::MODE_BEGIN: begin
        if (acc_r.hit) begin
          res_rid = key_r;
        end else begin
          res_err = tlt_pkg::ERR_TABLE_FULL;
        end
      end
      tlt_pkg::MODE_END: begin
        if (acc_r.hit) begin
          res_rid   = key_r;
          res_found = 1'b1;
          res_dur   = acc_r.dur;
          // Longest completed task wins; equal durations go to the larger id.
          best_upd  = !best_valid_r || (acc_r.dur > best_dur_r) ||
                      ((acc_r.dur == best_dur_r) && (key_r > best_id_r));
        end else begin
          res_err = tlt_pkg::ERR_UNKNOWN_ID;
        end
      end
      tlt_pkg::MODE_QUERY: begin
        // The completed record stands unless a running task is strictly longer.
        if (best_valid_r && !(acc_r.run_found && (best_dur_r < acc_r.dur))) begin
          res_rid   = best_id_r;
          res_found = 1'b1;
          res_dur   = best_dur_r;
        end else if (acc_r.run_found) begin
          res_rid   = acc_r.id;
          res_found = 1'b1;
          res_run   = 1'b1;
          res_dur   = acc_r.dur;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      next_id_r    <= '0;
      best_valid_r <= 1'b0;
      best_dur_r   <= '0;
      best_id_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // A new result loads the register; otherwise a taken result empties it.
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            mode_r <= tlt_pkg::mode_t'(in_ch.mode);
            key_r  <= (tlt_pkg::mode_t'(in_ch.mode) == tlt_pkg::MODE_BEGIN) ?
                      next_id_r : in_ch.task_id;
            now_r  <= in_ch.now;
            acc_r  <= '0;
            cnt_r  <= '0;
            state_r <= (tlt_pkg::mode_t'(in_ch.mode) == tlt_pkg::MODE_CLEAR) ?
                       ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(RUNNING_SLOTS - 1)) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_rid_r   <= res_rid;
            out_found_r <= res_found;
            out_run_r   <= res_run;
            out_dur_r   <= res_dur;
            out_err_r   <= res_err;
            if ((mode_r == tlt_pkg::MODE_BEGIN) && acc_r.hit) begin
              next_id_r <= key_r + 1'b1;
            end
            if (best_upd) begin
              best_valid_r <= 1'b1;
              best_dur_r   <= acc_r.dur;
              best_id_r    <= key_r;
            end
            if (mode_r == tlt_pkg::MODE_CLEAR) begin
              best_valid_r <= 1'b0;
              best_dur_r   <= '0;
              best_id_r    <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.result_id  = out_rid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.is_running = out_run_r;
  assign out_ch.duration   = out_dur_r;
  assign out_ch.error      = out_err_r;

endmodule

// File: rtl/tlt_cell.sv
// One slot of the running-task ring: holds valid, id and start time and loads
// its neighbor's slot whenever the ring rotates. Depends on tlt_pkg.
module tlt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  tlt_pkg::slot_t slot_in,
  output tlt_pkg::slot_t slot_q
);

  logic                       valid_r;
  logic [tlt_pkg::ID_W-1:0]   id_r;
  logic [tlt_pkg::TIME_W-1:0] start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= slot_in.valid;
    end
  end

  // Id and start time are only looked at while the slot is valid.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      id_r    <= slot_in.id;
      start_r <= slot_in.start;
    end
  end

  assign slot_q = '{valid: valid_r, id: id_r, start: start_r};

endmodule

// File: rtl/tlt_head.sv
// Head-of-ring logic: examines the slot at the ring head for the current transaction,
// produces the slot to write back at the tail and the updated scan accumulator.
// Depends on tlt_pkg.
module tlt_head (
  input  tlt_pkg::mode_t              mode,
  input  logic [tlt_pkg::ID_W-1:0]    key,
  input  logic [tlt_pkg::TIME_W-1:0]  now,
  input  tlt_pkg::slot_t              head,
  input  tlt_pkg::acc_t               acc,
  output tlt_pkg::slot_t              head_nxt,
  output tlt_pkg::acc_t               acc_nxt
);

  logic [tlt_pkg::TIME_W-1:0] elapsed;
  logic                       match;

  assign elapsed = now - head.start;
  assign match   = head.valid && (head.id == key);

  always_comb begin
    head_nxt = head;
    acc_nxt  = acc;
    case (mode)
      tlt_pkg::MODE_BEGIN: begin
        // The first matching or free slot takes the new task. A match found
        // after a free slot was already taken is dropped, so the id ends up
        // stored exactly once.
        if (match) begin
          if (acc.hit) begin
            head_nxt.valid = 1'b0;
          end else begin
            head_nxt.start = now;
            acc_nxt.hit    = 1'b1;
          end
        end else if (!head.valid && !acc.hit) begin
          head_nxt    = '{valid: 1'b1, id: key, start: now};
          acc_nxt.hit = 1'b1;
        end
      end
      tlt_pkg::MODE_END: begin
        if (match) begin
          head_nxt.valid = 1'b0;
          acc_nxt.hit    = 1'b1;
          acc_nxt.dur    = elapsed;
        end
      end
      tlt_pkg::MODE_QUERY: begin
        // The maximum starts at zero, so a task needs a nonzero duration to
        // qualify; equal durations go to the lower id.
        if (head.valid && ((elapsed > acc.dur) ||
            (acc.run_found && (elapsed == acc.dur) && (head.id < acc.id)))) begin
          acc_nxt.run_found = 1'b1;
          acc_nxt.dur       = elapsed;
          acc_nxt.id        = head.id;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: tb/task_latency_tracker_tb.sv
// Self-checking testbench for task_latency_tracker: directed cases, then random traffic.
// Depends on tlt_pkg, tlt_in_if, tlt_out_if and the task_latency_tracker RTL.
// Every result is checked against a behavioral copy of the tracker kept in this module.
module task_latency_tracker_tb;
  import tlt_pkg::*;

  localparam int SLOTS = DEFAULT_RUNNING_SLOTS;
  // DRAIN_CYCLES covers two transactions, each a ring turn plus its idle and finish
  // states, plus margin: enough to see any stray result after the last expected one.
  localparam int DRAIN_CYCLES = 2 * (SLOTS + 2) + 8;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int RANDOM_REQUESTS = 1100;

  // One result as it should appear on the result channel.
  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic              found;
    logic              is_running;
    logic [TIME_W-1:0] duration;
    err_t              error;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlt_in_if  in_ch();
  tlt_out_if out_ch();

  task_latency_tracker #(
    .RUNNING_SLOTS(SLOTS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral copy of the tracker: the running table, the completed record
  // and the id counter.
  logic              live_valid [SLOTS];
  logic [ID_W-1:0]   live_id    [SLOTS];
  logic [TIME_W-1:0] live_start [SLOTS];
  logic              rec_valid;
  logic [TIME_W-1:0] rec_dur;
  logic [ID_W-1:0]   rec_id;
  logic [ID_W-1:0]   id_counter;

  // Results still owed by the block, oldest first.
  report_t pending_reports[$];

  int  mismatch_count = 0;
  int  reports_checked = 0;
  int  mode_count[4] = '{0, 0, 0, 0};
  int  full_count = 0;
  int  unknown_count = 0;
  // When clear, both the request side and the result side run without gaps.
  bit  idle_on = 1'b1;
  // The timestamp that random traffic presents next.
  logic [TIME_W-1:0] clock_ms;

  // Applies one accepted transaction to the copy of the tracker and returns
  // the result that the block must produce for it.
  function automatic report_t track_request(mode_t op, logic [ID_W-1:0] tid,
                                            logic [TIME_W-1:0] stamp);
    report_t           rep;
    int                slot;
    logic [TIME_W-1:0] age;
    logic              run_hit;
    logic [TIME_W-1:0] run_age;
    logic [ID_W-1:0]   run_id;
    rep = '0;
    rep.error = ERR_NONE;
    slot = -1;
    run_hit = 1'b0;
    run_age = '0;
    run_id = '0;
    case (op)
      MODE_BEGIN: begin
        // A slot already holding the new id is reused; otherwise the first free one.
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && live_valid[i] && live_id[i] == id_counter) slot = i;
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && !live_valid[i]) slot = i;
        if (slot < 0) begin
          rep.error = ERR_TABLE_FULL;
        end else begin
          live_valid[slot] = 1'b1;
          live_id[slot] = id_counter;
          live_start[slot] = stamp;
          rep.result_id = id_counter;
          id_counter = id_counter + 1'b1;
        end
      end
      MODE_END: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && live_valid[i] && live_id[i] == tid) slot = i;
        if (slot < 0) begin
          rep.error = ERR_UNKNOWN_ID;
        end else begin
          age = stamp - live_start[slot];
          live_valid[slot] = 1'b0;
          // Longest completed task wins; on equal durations the larger id.
          if (!rec_valid || age > rec_dur || (age == rec_dur && tid > rec_id)) begin
            rec_valid = 1'b1;
            rec_dur = age;
            rec_id = tid;
          end
          rep.result_id = tid;
          rep.found = 1'b1;
          rep.duration = age;
        end
      end
      MODE_QUERY: begin
        // Running maximum: zero durations never qualify, ties go to the lower id.
        for (int i = 0; i < SLOTS; i++) begin
          if (live_valid[i]) begin
            age = stamp - live_start[i];
            if (age > run_age || (run_hit && age == run_age && live_id[i] < run_id)) begin
              run_hit = 1'b1;
              run_age = age;
              run_id = live_id[i];
            end
          end
        end
        // The completed record stands unless a running task is strictly longer.
        if (rec_valid && !(run_hit && run_age > rec_dur)) begin
          rep.result_id = rec_id;
          rep.found = 1'b1;
          rep.duration = rec_dur;
        end else if (run_hit) begin
          rep.result_id = run_id;
          rep.found = 1'b1;
          rep.is_running = 1'b1;
          rep.duration = run_age;
        end
      end
      default: begin
        rec_valid = 1'b0;
        rec_dur = '0;
        rec_id = '0;
      end
    endcase
    return rep;
  endfunction

  // Presents one request, after a random gap while gaps are on, and waits until it is accepted.
  // The expected result is computed at the accepting edge, so the copy of the
  // tracker moves in step with the block.
  task automatic issue_request(mode_t op, logic [ID_W-1:0] tid, logic [TIME_W-1:0] stamp);
    int      gap;
    report_t rep;
    @(negedge clk);
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode    <= op;
    in_ch.task_id <= tid;
    in_ch.now     <= stamp;
    in_ch.valid   <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    rep = track_request(op, tid, stamp);
    pending_reports.push_back(rep);
    mode_count[op]++;
    if (rep.error == ERR_TABLE_FULL) full_count++;
    if (rep.error == ERR_UNKNOWN_ID) unknown_count++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Empty tracker: a query finds nothing, and ending an id that was never
  // handed out is rejected. Both use all-ones in the fields that are ignored
  // or looked up.
  task automatic test_empty_tracker();
    issue_request(MODE_QUERY, '1, '0);
    issue_request(MODE_END, '1, TIME_MAX);
  endtask

  // Fills every running slot, then one more begin must report a full table
  // without consuming an id. Ids 0 and 1 start earlier than the rest.
  task automatic test_table_full();
    for (int i = 0; i < SLOTS; i++)
      issue_request(MODE_BEGIN, $urandom, (i < 2) ? 48'd100 : 48'd150);
    issue_request(MODE_BEGIN, '0, 48'd150);
  endtask

  // Tie rules. At time 150 ids 0 and 1 have run 50 ms and the rest 0 ms, so
  // the running maximum is id 0. Ending id 1 gives a completed record of 50,
  // which then beats the equally long running id 0. Ending id 5 at 200 also
  // takes 50 ms, and the larger id takes over the record.
  task automatic test_ranking_ties();
    issue_request(MODE_QUERY, '0, 48'd150);
    issue_request(MODE_END, 32'd1, 48'd150);
    issue_request(MODE_QUERY, '0, 48'd150);
    issue_request(MODE_END, 32'd5, 48'd200);
  endtask

  // Time going backwards: ending id 15 at time 0 wraps to a huge duration.
  // A query at the top of the time range then finds id 0 running just
  // longer than that. After a clear only running tasks remain to report.
  task automatic test_clear_and_wrap();
    issue_request(MODE_END, 32'd15, '0);
    issue_request(MODE_QUERY, '0, TIME_MAX);
    issue_request(MODE_CLEAR, '1, '0);
    issue_request(MODE_QUERY, '0, 48'd300);
  endtask

  // Random traffic. Most ends name a task that is really running, so the
  // table churns and both rankings see many candidates; the rest use random
  // or stale ids. Time mostly creeps forward in small steps (which gives
  // ties and zero durations), now and then steps back or jumps anywhere.
  // Gaps on both channels are switched on and off in stretches of 100.
  task automatic test_random_traffic(int count);
    int             pick;
    int             live_total;
    int             chosen;
    mode_t          op;
    logic [ID_W-1:0] tid;
    clock_ms = 48'd300;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 2)
        clock_ms = TIME_W'({$urandom, $urandom});
      else if (pick < 5)
        clock_ms = clock_ms - $urandom_range(1, 500);
      else
        clock_ms = clock_ms + $urandom_range(0, 30);
      tid = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        op = MODE_CLEAR;
      end else if (pick < 22) begin
        op = MODE_QUERY;
      end else if (pick < 64) begin
        op = MODE_END;
        live_total = 0;
        for (int i = 0; i < SLOTS; i++)
          if (live_valid[i]) live_total++;
        if (live_total > 0 && $urandom_range(0, 7) != 0) begin
          chosen = $urandom_range(0, live_total - 1);
          for (int i = 0; i < SLOTS; i++) begin
            if (live_valid[i]) begin
              if (chosen == 0) tid = live_id[i];
              chosen--;
            end
          end
        end else if ($urandom_range(0, 1) == 0) begin
          // Most recently issued id; it may already have ended.
          tid = id_counter - 1'b1;
        end
      end else begin
        op = MODE_BEGIN;
      end
      issue_request(op, tid, clock_ms);
    end
  endtask

  // Result side: a random stall before each result while gaps are on, then ready
  // stays high until a transaction completes.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result id=%h found=%b running=%b duration=%h error=%0d",
                   out_ch.result_id, out_ch.found, out_ch.is_running, out_ch.duration,
                   out_ch.error);
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.result_id !== want.result_id || out_ch.found !== want.found ||
            out_ch.is_running !== want.is_running || out_ch.duration !== want.duration ||
            out_ch.error !== want.error) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: result %0d expected id=%h found=%b running=%b duration=%h error=%0d",
                     reports_checked, want.result_id, want.found, want.is_running,
                     want.duration, want.error);
            $display("       got                id=%h found=%b running=%b duration=%h error=%0d",
                     out_ch.result_id, out_ch.found, out_ch.is_running, out_ch.duration,
                     out_ch.error);
          end
        end
        reports_checked++;
      end
    end
  end

  initial begin : run
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_BEGIN;
    in_ch.task_id = '0;
    in_ch.now     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      live_valid[i] = 1'b0;
      live_id[i]    = '0;
      live_start[i] = '0;
    end
    rec_valid  = 1'b0;
    rec_dur    = '0;
    rec_id     = '0;
    id_counter = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_tracker();
    test_table_full();
    test_ranking_ties();
    test_clear_and_wrap();
    test_random_traffic(RANDOM_REQUESTS);

    // Let every owed result arrive, then watch a while for stray ones.
    idle_input();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d begin, %0d end, %0d query and %0d clear transactions.",
             mode_count[MODE_BEGIN], mode_count[MODE_END], mode_count[MODE_QUERY],
             mode_count[MODE_CLEAR]);
    $display("Checked %0d results (%0d with a full table, %0d with an unknown id), %0d bad.",
             reports_checked, full_count, unknown_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The slowest correct run is about 1150 transactions, under half a million
  // time units; this limit is several times that.
  initial begin : watchdog
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
